FILE: rtl/http_request_byte_tokenizer_assert.svh
// Assertion macros for the HTTP request byte tokenizer.
// Needs clk_i and rst_ni in the scope where the macros are used.
`ifndef HTTP_REQUEST_BYTE_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_BYTE_TOKENIZER_ASSERT_SVH

`ifndef SYNTH
`define HRBT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hrbt assertion failed");
`define HRBT_ASSERT_NEVER(lbl, expr) \
  `HRBT_ASSERT(lbl, !(expr))
`else
`define HRBT_ASSERT(lbl, prop)
`define HRBT_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: rtl/hrbt_pkg.sv
// Package for the HTTP request byte tokenizer: phase, section and method
// codes, character constants and the method match function. No dependencies.
package hrbt_pkg;

  // parse phases
  localparam logic [3:0] PH_METHOD  = 4'd0;
  localparam logic [3:0] PH_ROUTE   = 4'd1;
  localparam logic [3:0] PH_QKEY    = 4'd2;
  localparam logic [3:0] PH_QVAL    = 4'd3;
  localparam logic [3:0] PH_VERSION = 4'd4;
  localparam logic [3:0] PH_HNAME   = 4'd5;
  localparam logic [3:0] PH_HSKIP   = 4'd6;
  localparam logic [3:0] PH_HVAL    = 4'd7;
  localparam logic [3:0] PH_BODY    = 4'd8;

  // section tags
  localparam logic [3:0] SEC_METHOD  = 4'd0;
  localparam logic [3:0] SEC_ROUTE   = 4'd1;
  localparam logic [3:0] SEC_QKEY    = 4'd2;
  localparam logic [3:0] SEC_QVAL    = 4'd3;
  localparam logic [3:0] SEC_VERSION = 4'd4;
  localparam logic [3:0] SEC_HNAME   = 4'd5;
  localparam logic [3:0] SEC_HVAL    = 4'd6;
  localparam logic [3:0] SEC_BODY    = 4'd7;
  localparam logic [3:0] SEC_DELIM   = 4'd8;

  // method codes
  localparam logic [1:0] METH_GET  = 2'd0;
  localparam logic [1:0] METH_POST = 2'd1;
  localparam logic [1:0] METH_HEAD = 2'd2;
  localparam logic [1:0] METH_NONE = 2'd3;

  localparam logic [2:0] METH_CNT_MAX = 3'd5;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [31:0] WORD_GET  = 32'h0047_4554;
  localparam logic [31:0] WORD_POST = 32'h504F_5354;
  localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

  // exact-length match of the collected method bytes
  function automatic logic [1:0] match_method(logic [31:0] chars, logic [2:0] cnt);
    logic [1:0] res;
    res = METH_NONE;
    if (cnt == 3'd3 && chars == WORD_GET) begin
      res = METH_GET;
    end else if (cnt == 3'd4 && chars == WORD_POST) begin
      res = METH_POST;
    end else if (cnt == 3'd4 && chars == WORD_HEAD) begin
      res = METH_HEAD;
    end
    return res;
  endfunction

endpackage

FILE: rtl/hrbt_if.sv
// Channel interfaces of the HTTP request byte tokenizer: request bytes in,
// per-byte tags out. Valid/ready handshake. No dependencies.
interface hrbt_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface hrbt_tag_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [3:0] section;
  logic       token_end;
  logic [1:0] method_code;
  logic       method_done;
  logic       headers_done;

  modport source (output valid, echo_byte, section, token_end, method_code,
                  method_done, headers_done, input ready);
  modport sink   (input valid, echo_byte, section, token_end, method_code,
                  method_done, headers_done, output ready);
endinterface

FILE: rtl/http_request_byte_tokenizer.sv
// Channel   | Dir | Payload                                         | Handshake
// req_i     | in  | data_byte, frame_start                          | valid/ready
// tag_o     | out | echo_byte, section, token_end, method_code,     | valid/ready
//           |     | method_done, headers_done                       |
// One byte per cycle while tag_o does not stall; the tag appears in the cycle after its transfer in.
// Throughput is set by the phase update, a single compare/select step.
// rst_ni clears the phase machine and the output valid; frame_start also
// returns the parser to its reset state before that byte is classified.
// A stalled tag holds; req_i.ready stays high while the tag is taken.
//
// Depends on hrbt_pkg, hrbt_if.sv and http_request_byte_tokenizer_assert.svh.
`include "http_request_byte_tokenizer_assert.svh"

module http_request_byte_tokenizer (
  input logic         clk_i,
  input logic         rst_ni,
  hrbt_req_if.sink    req_i,
  hrbt_tag_if.source  tag_o
);

  logic [3:0]  phase_q, phase_d;
  logic [31:0] mchars_q, mchars_d;
  logic [2:0]  mcount_q, mcount_d;
  logic [1:0]  mresult_q, mresult_d;
  logic        saw_cr_q, saw_cr_d;
  logic        line_empty_q, line_empty_d;

  logic        out_valid_q;
  logic [7:0]  echo_q;
  logic [3:0]  sec_q, sec_d;
  logic        tend_q, tend_d;
  logic [1:0]  mcode_q;
  logic        mdone_q, mdone_d;
  logic        hdone_q, hdone_d;

  logic        accept;
  logic [7:0]  b;
  logic        is_eol;

  assign req_i.ready = !out_valid_q || tag_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign b           = req_i.data_byte;
  assign is_eol      = (b == hrbt_pkg::CH_CR) || (b == hrbt_pkg::CH_LF);

  always_comb begin
    logic [3:0]  ph;
    logic [31:0] mc;
    logic [2:0]  cnt;
    logic [1:0]  mres;
    logic        cr;
    logic        le;
    // frame_start behaves like a reset applied ahead of this byte
    ph   = req_i.frame_start ? hrbt_pkg::PH_METHOD : phase_q;
    mc   = req_i.frame_start ? 32'd0 : mchars_q;
    cnt  = req_i.frame_start ? 3'd0 : mcount_q;
    mres = req_i.frame_start ? hrbt_pkg::METH_NONE : mresult_q;
    cr   = req_i.frame_start ? 1'b0 : saw_cr_q;
    le   = req_i.frame_start ? 1'b0 : line_empty_q;

    phase_d      = ph;
    mchars_d     = mc;
    mcount_d     = cnt;
    mresult_d    = mres;
    saw_cr_d     = cr;
    line_empty_d = le;
    sec_d        = hrbt_pkg::SEC_DELIM;
    tend_d       = 1'b0;
    mdone_d      = 1'b0;
    hdone_d      = 1'b0;

    unique case (ph)
      hrbt_pkg::PH_METHOD: begin
        if (b == hrbt_pkg::CH_SP) begin
          mresult_d = hrbt_pkg::match_method(mc, cnt);
          mdone_d   = 1'b1;
          tend_d    = 1'b1;
          phase_d   = hrbt_pkg::PH_ROUTE;
        end else begin
          sec_d    = hrbt_pkg::SEC_METHOD;
          mchars_d = {mc[23:0], b};
          if (cnt < hrbt_pkg::METH_CNT_MAX) mcount_d = cnt + 3'd1;
        end
      end
      hrbt_pkg::PH_ROUTE: begin
        if (b == hrbt_pkg::CH_SP) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_VERSION;
        end else if (b == hrbt_pkg::CH_QMARK) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_QKEY;
        end else begin
          sec_d = hrbt_pkg::SEC_ROUTE;
        end
      end
      hrbt_pkg::PH_QKEY: begin
        if (b == hrbt_pkg::CH_SP) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_VERSION;
        end else if (b == hrbt_pkg::CH_EQ) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_QVAL;
        end else begin
          sec_d = hrbt_pkg::SEC_QKEY;
        end
      end
      hrbt_pkg::PH_QVAL: begin
        if (b == hrbt_pkg::CH_SP) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_VERSION;
        end else if (b == hrbt_pkg::CH_AMP) begin
          tend_d = 1'b1; phase_d = hrbt_pkg::PH_QKEY;
        end else begin
          sec_d = hrbt_pkg::SEC_QVAL;
        end
      end
      hrbt_pkg::PH_VERSION, hrbt_pkg::PH_HVAL: begin
        if (is_eol) begin
          tend_d = !cr;  // LF right after CR closes nothing new
          if (b == hrbt_pkg::CH_LF) begin
            saw_cr_d = 1'b0; line_empty_d = 1'b1; phase_d = hrbt_pkg::PH_HNAME;
          end else begin
            saw_cr_d = 1'b1;
          end
        end else begin
          saw_cr_d = 1'b0;
          sec_d    = (ph == hrbt_pkg::PH_VERSION) ? hrbt_pkg::SEC_VERSION
                                                  : hrbt_pkg::SEC_HVAL;
        end
      end
      hrbt_pkg::PH_HNAME: begin
        if (is_eol) begin
          tend_d = le ? 1'b0 : !cr;
          if (b == hrbt_pkg::CH_LF) begin
            saw_cr_d = 1'b0;
            if (le) begin
              // blank line: headers over
              hdone_d = 1'b1; line_empty_d = 1'b0; phase_d = hrbt_pkg::PH_BODY;
            end else begin
              line_empty_d = 1'b1;
            end
          end else begin
            saw_cr_d = 1'b1;
          end
        end else if (b == hrbt_pkg::CH_COLON) begin
          saw_cr_d = 1'b0; line_empty_d = 1'b0; tend_d = 1'b1;
          phase_d  = hrbt_pkg::PH_HSKIP;
        end else begin
          saw_cr_d = 1'b0; line_empty_d = 1'b0; sec_d = hrbt_pkg::SEC_HNAME;
        end
      end
      hrbt_pkg::PH_HSKIP: begin
        if (is_eol) begin
          if (b == hrbt_pkg::CH_LF) begin
            saw_cr_d = 1'b0; line_empty_d = 1'b1; phase_d = hrbt_pkg::PH_HNAME;
          end else begin
            saw_cr_d = 1'b1; phase_d = hrbt_pkg::PH_HVAL;
          end
        end else if (b != hrbt_pkg::CH_SP) begin
          sec_d = hrbt_pkg::SEC_HVAL; phase_d = hrbt_pkg::PH_HVAL;
        end
      end
      default: begin
        // body, and unused phase codes
        sec_d = hrbt_pkg::SEC_BODY;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= hrbt_pkg::PH_METHOD;
      mchars_q     <= 32'd0;
      mcount_q     <= 3'd0;
      mresult_q    <= hrbt_pkg::METH_NONE;
      saw_cr_q     <= 1'b0;
      line_empty_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        mchars_q     <= mchars_d;
        mcount_q     <= mcount_d;
        mresult_q    <= mresult_d;
        saw_cr_q     <= saw_cr_d;
        line_empty_q <= line_empty_d;
        out_valid_q  <= 1'b1;
      end else if (tag_o.ready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      echo_q  <= b;
      sec_q   <= sec_d;
      tend_q  <= tend_d;
      mcode_q <= mresult_d;
      mdone_q <= mdone_d;
      hdone_q <= hdone_d;
    end
  end

  assign tag_o.valid        = out_valid_q;
  assign tag_o.echo_byte    = echo_q;
  assign tag_o.section      = sec_q;
  assign tag_o.token_end    = tend_q;
  assign tag_o.method_code  = mcode_q;
  assign tag_o.method_done  = mdone_q;
  assign tag_o.headers_done = hdone_q;

  `HRBT_ASSERT(a_tag_after_transfer, accept |=> out_valid_q)
  `HRBT_ASSERT(a_mdone_is_delim,
    (out_valid_q && mdone_q) |-> (sec_q == hrbt_pkg::SEC_DELIM && tend_q))
  `HRBT_ASSERT(a_hdone_enters_body,
    (out_valid_q && hdone_q) |-> (phase_q == hrbt_pkg::PH_BODY))
  `HRBT_ASSERT_NEVER(a_mcount_sat, mcount_q > hrbt_pkg::METH_CNT_MAX)
  `HRBT_ASSERT_NEVER(a_sec_range, out_valid_q && (sec_q > hrbt_pkg::SEC_DELIM))

endmodule

FILE: verif/http_request_byte_tokenizer_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for http_request_byte_tokenizer: drives request bytes
// with random gaps and stalls, predicts every tag and checks it field by field.
// Depends on hrbt_pkg, hrbt_if.sv and the RTL of the block.
module http_request_byte_tokenizer_tb;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_ITEMS  = 400;
  localparam int TAIL_CYCLES = 8;

  typedef struct packed {
    logic [7:0] echo;
    logic [3:0] section;
    logic       token_end;
    logic [1:0] method_code;
    logic       method_done;
    logic       headers_done;
  } tag_t;

  class byte_tag_board;
    logic [3:0]  phase;
    logic [31:0] mchars;
    logic [2:0]  mcount;
    logic [1:0]  mres;
    logic        cr_seen;
    logic        empty_line;
    tag_t        pending_tags[$];
    int          errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      phase      = hrbt_pkg::PH_METHOD;
      mchars     = '0;
      mcount     = '0;
      mres       = hrbt_pkg::METH_NONE;
      cr_seen    = 1'b0;
      empty_line = 1'b0;
    endfunction

    function int pending();
      return pending_tags.size();
    endfunction

    // input transfer: advance the parser copy and queue the tag it yields
    function void note_byte(logic [7:0] b, logic fs);
      tag_t t;
      if (fs) clear_state();
      t = '{echo: b, section: hrbt_pkg::SEC_DELIM, token_end: 1'b0,
            method_code: hrbt_pkg::METH_NONE, method_done: 1'b0, headers_done: 1'b0};
      case (phase)
        hrbt_pkg::PH_METHOD: begin
          if (b == hrbt_pkg::CH_SP) begin
            // full-length match only
            if (mcount == 3'd3 && mchars == hrbt_pkg::WORD_GET)
              mres = hrbt_pkg::METH_GET;
            else if (mcount == 3'd4 && mchars == hrbt_pkg::WORD_POST)
              mres = hrbt_pkg::METH_POST;
            else if (mcount == 3'd4 && mchars == hrbt_pkg::WORD_HEAD)
              mres = hrbt_pkg::METH_HEAD;
            else
              mres = hrbt_pkg::METH_NONE;
            t.method_done = 1'b1;
            t.token_end = 1'b1;
            phase = hrbt_pkg::PH_ROUTE;
          end else begin
            t.section = hrbt_pkg::SEC_METHOD;
            mchars = {mchars[23:0], b};
            if (mcount < hrbt_pkg::METH_CNT_MAX) mcount = mcount + 3'd1;
          end
        end
        hrbt_pkg::PH_ROUTE: begin
          if (b == hrbt_pkg::CH_SP) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_VERSION;
          end else if (b == hrbt_pkg::CH_QMARK) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_QKEY;
          end else begin
            t.section = hrbt_pkg::SEC_ROUTE;
          end
        end
        hrbt_pkg::PH_QKEY: begin
          if (b == hrbt_pkg::CH_SP) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_VERSION;
          end else if (b == hrbt_pkg::CH_EQ) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_QVAL;
          end else begin
            t.section = hrbt_pkg::SEC_QKEY;
          end
        end
        hrbt_pkg::PH_QVAL: begin
          if (b == hrbt_pkg::CH_SP) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_VERSION;
          end else if (b == hrbt_pkg::CH_AMP) begin
            t.token_end = 1'b1; phase = hrbt_pkg::PH_QKEY;
          end else begin
            t.section = hrbt_pkg::SEC_QVAL;
          end
        end
        hrbt_pkg::PH_VERSION, hrbt_pkg::PH_HVAL: begin
          if (b == hrbt_pkg::CH_CR || b == hrbt_pkg::CH_LF) begin
            t.token_end = ~cr_seen;
            if (b == hrbt_pkg::CH_LF) begin
              cr_seen = 1'b0; empty_line = 1'b1; phase = hrbt_pkg::PH_HNAME;
            end else begin
              cr_seen = 1'b1;
            end
          end else begin
            cr_seen = 1'b0;
            t.section = (phase == hrbt_pkg::PH_VERSION) ? hrbt_pkg::SEC_VERSION
                                                        : hrbt_pkg::SEC_HVAL;
          end
        end
        hrbt_pkg::PH_HNAME: begin
          if (b == hrbt_pkg::CH_CR || b == hrbt_pkg::CH_LF) begin
            t.token_end = empty_line ? 1'b0 : ~cr_seen;
            if (b == hrbt_pkg::CH_LF) begin
              cr_seen = 1'b0;
              if (empty_line) begin
                t.headers_done = 1'b1; empty_line = 1'b0; phase = hrbt_pkg::PH_BODY;
              end else begin
                empty_line = 1'b1;
              end
            end else begin
              cr_seen = 1'b1;
            end
          end else if (b == hrbt_pkg::CH_COLON) begin
            cr_seen = 1'b0; empty_line = 1'b0; t.token_end = 1'b1;
            phase = hrbt_pkg::PH_HSKIP;
          end else begin
            cr_seen = 1'b0; empty_line = 1'b0; t.section = hrbt_pkg::SEC_HNAME;
          end
        end
        hrbt_pkg::PH_HSKIP: begin
          if (b == hrbt_pkg::CH_LF) begin
            cr_seen = 1'b0; empty_line = 1'b1; phase = hrbt_pkg::PH_HNAME;
          end else if (b == hrbt_pkg::CH_CR) begin
            cr_seen = 1'b1; phase = hrbt_pkg::PH_HVAL;
          end else if (b != hrbt_pkg::CH_SP) begin
            t.section = hrbt_pkg::SEC_HVAL; phase = hrbt_pkg::PH_HVAL;
          end
        end
        default: t.section = hrbt_pkg::SEC_BODY;
      endcase
      t.method_code = mres;
      pending_tags.push_back(t);
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    // output transfer: compare with the oldest predicted tag
    function void check_tag(tag_t got);
      tag_t want;
      if (pending_tags.size() == 0) begin
        $error("tag transfer with no byte outstanding, echo_byte 0x%0h", got.echo);
        errors++;
        return;
      end
      want = pending_tags.pop_front();
      cmp_field("echo_byte", want.echo, got.echo);
      cmp_field("section", want.section, got.section);
      cmp_field("token_end", want.token_end, got.token_end);
      cmp_field("method_code", want.method_code, got.method_code);
      cmp_field("method_done", want.method_done, got.method_done);
      cmp_field("headers_done", want.headers_done, got.headers_done);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   items_sent = 0;
  bit   tx_steady = 1'b0;
  logic [7:0] req_bytes[$];
  byte_tag_board board;

  hrbt_req_if req_ch ();
  hrbt_tag_if tag_ch ();

  http_request_byte_tokenizer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .tag_o  (tag_ch)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) board.note_byte(req_ch.data_byte, req_ch.frame_start);
      if (tag_ch.valid && tag_ch.ready)
        board.check_tag('{tag_ch.echo_byte, tag_ch.section, tag_ch.token_end,
                          tag_ch.method_code, tag_ch.method_done, tag_ch.headers_done});
    end
  end

  // mostly no gap, some short ones, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, with stretches of steady ready
  initial begin
    int stall;
    int span;
    bit steady;
    stall = 0;
    span = 0;
    steady = 1'b0;
    tag_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        steady = ($urandom_range(0, 3) == 0);
        span = $urandom_range(20, 80);
      end
      span--;
      if (stall > 0) begin
        tag_ch.ready <= 1'b0;
        stall--;
      end else if (steady || $urandom_range(0, 3) != 0) begin
        tag_ch.ready <= 1'b1;
      end else begin
        tag_ch.ready <= 1'b0;
        stall = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data_byte <= b;
    req_ch.frame_start <= fs;
    do @(posedge clk); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic send_str(input string s, input logic fs_first);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fs_first && i == 0);
  endtask

  // hold the sender until every tag has been taken; sample at negedge so the
  // monitor has already run for the last edge
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [7:0] text_char();
    string punct;
    punct = "/.-_";
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h61, 8'h7A));
      1: return 8'($urandom_range(8'h41, 8'h5A));
      2: return 8'($urandom_range(8'h30, 8'h39));
      default: return punct[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic void append_str(string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  function automatic void append_text(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    repeat (n) req_bytes.push_back(text_char());
  endfunction

  function automatic void append_eol();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      req_bytes.push_back(hrbt_pkg::CH_CR);
    end else if (r == 9) begin
      // CR followed by content, then a proper line end
      req_bytes.push_back(hrbt_pkg::CH_CR);
      req_bytes.push_back(text_char());
      req_bytes.push_back(hrbt_pkg::CH_CR);
    end
    req_bytes.push_back(hrbt_pkg::CH_LF);
  endfunction

  // one request with random content, sometimes malformed, into req_bytes
  function automatic void build_request();
    int nq;
    int nh;
    int nbody;
    req_bytes.delete();
    case ($urandom_range(0, 8))
      0, 1: append_str("GET");
      2:    append_str("POST");
      3:    append_str("HEAD");
      4:    append_str("GETS");
      5:    append_str("HEA");
      6:    append_str("POSTED");
      7:    ;
      default: repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
    endcase
    req_bytes.push_back(hrbt_pkg::CH_SP);
    req_bytes.push_back("/");
    append_text(0, 3);
    if ($urandom_range(0, 1)) begin
      req_bytes.push_back(hrbt_pkg::CH_QMARK);
      nq = $urandom_range(1, 3);
      for (int i = 0; i < nq; i++) begin
        if (i > 0) req_bytes.push_back(hrbt_pkg::CH_AMP);
        append_text(0, 3);
        if ($urandom_range(0, 3) != 0) begin
          req_bytes.push_back(hrbt_pkg::CH_EQ);
          append_text(0, 3);
        end
      end
    end
    req_bytes.push_back(hrbt_pkg::CH_SP);
    append_text(1, 3);
    append_eol();
    nh = $urandom_range(0, 2);
    repeat (nh) begin
      append_text(1, 3);
      if ($urandom_range(0, 5) != 0) begin
        req_bytes.push_back(hrbt_pkg::CH_COLON);
        repeat ($urandom_range(0, 2)) req_bytes.push_back(hrbt_pkg::CH_SP);
        append_text(0, 3);
      end
      append_eol();
    end
    append_eol();
    nbody = $urandom_range(0, 4);
    repeat (nbody) req_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  initial begin
    logic [7:0] delims[7];
    int n;
    bit mid_drained;
    delims = '{hrbt_pkg::CH_SP, hrbt_pkg::CH_CR, hrbt_pkg::CH_LF, hrbt_pkg::CH_QMARK,
               hrbt_pkg::CH_EQ, hrbt_pkg::CH_AMP, hrbt_pkg::CH_COLON};
    mid_drained = 1'b0;
    board = new();
    req_ch.valid <= 1'b0;
    req_ch.data_byte <= '0;
    req_ch.frame_start <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty method, route without query, CR then content, LF-only line end,
    // header without colon, empty header value, body with byte extremes
    send_byte(hrbt_pkg::CH_SP, 1'b1);
    send_str("/", 1'b0);
    send_byte(hrbt_pkg::CH_SP, 1'b0);
    send_str("V", 1'b0);
    send_byte(hrbt_pkg::CH_CR, 1'b0);
    send_str("x", 1'b0);
    send_byte(hrbt_pkg::CH_LF, 1'b0);
    send_str("N", 1'b0);
    send_byte(hrbt_pkg::CH_CR, 1'b0);
    send_byte(hrbt_pkg::CH_LF, 1'b0);
    send_byte(hrbt_pkg::CH_COLON, 1'b0);
    send_byte(hrbt_pkg::CH_LF, 1'b0);
    send_byte(hrbt_pkg::CH_LF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    // restart mid-body, query key without value
    send_str("POST /?k a", 1'b1);
    wait_drained();

    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        build_request();
        // sometimes cut short so the next frame start lands mid-request
        if ($urandom_range(0, 6) == 0 && req_bytes.size() > 1) begin
          n = $urandom_range(1, req_bytes.size() - 1);
          while (req_bytes.size() > n) void'(req_bytes.pop_back());
        end
        foreach (req_bytes[i]) send_byte(req_bytes[i], i == 0);
      end else begin
        n = $urandom_range(2, 10);
        for (int i = 0; i < n; i++)
          send_byte($urandom_range(0, 1) ? delims[$urandom_range(0, 6)]
                                         : 8'($urandom_range(0, 255)),
                    (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0));
      end
      if (!mid_drained && items_sent >= RAND_ITEMS / 2) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
